>>> hdl/qrs_pkg.sv
package qrs_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int TOL_BITS  = 17;

  localparam int PROD_BITS = 2 * WORD_BITS;
  // Signed discriminant: |b^2 - 4ac| stays below 2^(2W+1).
  localparam int DISC_BITS = 2 * WORD_BITS + 2;

  // First divider: magnitude of c shifted left by up to 2F, divided by |a| or |b|.
  localparam int N1_BITS = WORD_BITS + 2 * FRAC_BITS;
  localparam int R1_BITS = WORD_BITS + 1;

  // Square root of either the first quotient or the discriminant.
  localparam int RAD_RAW   = (N1_BITS > 2 * WORD_BITS + 1) ? N1_BITS : 2 * WORD_BITS + 1;
  localparam int RAD_BITS  = RAD_RAW + (RAD_RAW % 2);
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int SREM_BITS = ROOT_BITS + 3;

  // Second divider pair: (-b +- sqrt(D)) << F divided by 2|a|.
  localparam int M_BITS  = ROOT_BITS + 1;
  localparam int N2_BITS = M_BITS + FRAC_BITS;
  localparam int D2_BITS = WORD_BITS + 1;
  localparam int R2_BITS = D2_BITS + 1;

  localparam int EMIT_RAW  = (N1_BITS > N2_BITS) ? N1_BITS : N2_BITS;
  localparam int EMIT_BITS = (EMIT_RAW > ROOT_BITS) ? EMIT_RAW : ROOT_BITS;

  // Pipeline stage map.
  localparam int S_SPLIT = 0;
  localparam int S_PROD  = 1;
  localparam int S_DISC  = 2;
  localparam int S_DIV1  = 3;
  localparam int S_SQRT  = S_DIV1 + N1_BITS;
  localparam int S_PREP  = S_SQRT + ROOT_BITS;
  localparam int S_DIV2  = S_PREP + 1;
  localparam int S_OUT   = S_DIV2 + N2_BITS;

  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_ONE  = 2'd1;
  localparam logic [1:0] KIND_TWO  = 2'd2;
  localparam logic [1:0] KIND_ANY  = 2'd3;

  typedef enum logic [2:0] {
    MODE_ANY       = 3'd0,
    MODE_LINEAR    = 3'd1,
    MODE_ZERO_ROOT = 3'd2,
    MODE_SQRT      = 3'd3,
    MODE_NONE      = 3'd4,
    MODE_GENERAL   = 3'd5,
    MODE_GEN_ONE   = 3'd6,
    MODE_GEN_TWO   = 3'd7
  } mode_e;

  typedef struct packed {
    mode_e                  mode;
    logic                   an;
    logic                   bn;
    logic                   cn;
    logic [WORD_BITS-1:0]   am;
    logic [WORD_BITS-1:0]   bm;
    logic [WORD_BITS-1:0]   cm;
    logic [PROD_BITS-1:0]   b2;
    logic [PROD_BITS-1:0]   ac;
    logic [RAD_BITS-1:0]    rad;
    logic [N1_BITS-1:0]     n1;
    logic [N1_BITS-1:0]     q1;
    logic [WORD_BITS-1:0]   d1;
    logic [R1_BITS-1:0]     r1;
    logic [SREM_BITS-1:0]   srem;
    logic [ROOT_BITS-1:0]   sroot;
    logic                   neg1;
    logic                   neg2;
    logic [N2_BITS-1:0]     n2a;
    logic [N2_BITS-1:0]     n2b;
    logic [N2_BITS-1:0]     q2a;
    logic [N2_BITS-1:0]     q2b;
    logic [R2_BITS-1:0]     r2a;
    logic [R2_BITS-1:0]     r2b;
    logic [D2_BITS-1:0]     d2;
  } pl_t;

  typedef struct packed {
    logic                 ov;
    logic [WORD_BITS-1:0] val;
  } emit_t;

endpackage

>>> hdl/quadratic_root_solver.sv
// From an input transfer to the result being offered, each coefficient set passes the
// stages of the map in qrs_pkg; the two long dividers and the root extractor
// each resolve one bit per stage.
// Throughput: one coefficient set per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous, active low; clears all valid bits and sets tol_q to 1.
module quadratic_root_solver import qrs_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [TOL_BITS-1:0]         cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic signed [WORD_BITS-1:0] coef_a_i,
  input  logic signed [WORD_BITS-1:0] coef_b_i,
  input  logic signed [WORD_BITS-1:0] coef_c_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  root_kind_o,
  output logic signed [WORD_BITS-1:0] root_first_o,
  output logic signed [WORD_BITS-1:0] root_second_o,
  output logic                        overflow_o
);

  // Tolerance register. A stored zero behaves as one so that only exact zeros count.
  logic [TOL_BITS-1:0] tol_q;
  logic [TOL_BITS-1:0] tol_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TOL_BITS'(1);
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  assign tol_eff = (tol_q == '0) ? TOL_BITS'(1) : tol_q;

  // The pipeline moves as one. It advances unless a finished result is held by a
  // stalled receiver, so the output register parts both sides and nothing is lost.
  logic adv;
  logic [S_OUT-1:0] vld_q;
  pl_t st_q [S_OUT];
  pl_t st_d [S_OUT];

  logic                 out_vld_q;
  logic [1:0]           kind_q,   kind_d;
  logic [WORD_BITS-1:0] first_q,  first_d;
  logic [WORD_BITS-1:0] second_q, second_d;
  logic                 ov_q,     ov_d;

  assign adv        = !out_vld_q || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[S_OUT-2:0], in_valid_i};
      out_vld_q <= vld_q[S_OUT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < S_OUT; i++) begin
        st_q[i] <= st_d[i];
      end
      kind_q   <= kind_d;
      first_q  <= first_d;
      second_q <= second_d;
      ov_q     <= ov_d;
    end
  end

  // Stage 0: split each coefficient into sign and magnitude. The most negative word
  // gives a magnitude of exactly 2^(W-1), which the unsigned negate already yields.
  always_comb begin
    logic [WORD_BITS-1:0] ua, ub, uc;
    ua = coef_a_i;
    ub = coef_b_i;
    uc = coef_c_i;
    st_d[S_SPLIT]      = '0;
    st_d[S_SPLIT].mode = MODE_ANY;
    st_d[S_SPLIT].an   = ua[WORD_BITS-1];
    st_d[S_SPLIT].bn   = ub[WORD_BITS-1];
    st_d[S_SPLIT].cn   = uc[WORD_BITS-1];
    st_d[S_SPLIT].am   = ua[WORD_BITS-1] ? -ua : ua;
    st_d[S_SPLIT].bm   = ub[WORD_BITS-1] ? -ub : ub;
    st_d[S_SPLIT].cm   = uc[WORD_BITS-1] ? -uc : uc;
  end

  // Stage 1: classify against the tolerance, form b^2 and a*c, and load the first
  // divider. It serves the linear root -c/b and the ratio c/a under the square root.
  always_comb begin
    logic a_small, b_small, c_small;
    logic [WORD_BITS-1:0] tol_w;
    pl_t  x;
    x      = st_q[S_SPLIT];
    tol_w  = WORD_BITS'(tol_eff);
    a_small = x.am < tol_w;
    b_small = x.bm < tol_w;
    c_small = x.cm < tol_w;
    st_d[S_PROD]    = x;
    st_d[S_PROD].b2 = PROD_BITS'(x.bm) * PROD_BITS'(x.bm);
    st_d[S_PROD].ac = PROD_BITS'(x.am) * PROD_BITS'(x.cm);
    st_d[S_PROD].r1 = '0;
    st_d[S_PROD].q1 = '0;
    st_d[S_PROD].d1 = x.am;
    st_d[S_PROD].n1 = '0;
    if (a_small) begin
      if (b_small) begin
        st_d[S_PROD].mode = MODE_ANY;
      end else begin
        st_d[S_PROD].mode = MODE_LINEAR;
        st_d[S_PROD].n1   = N1_BITS'(x.cm) << FRAC_BITS;
        st_d[S_PROD].d1   = x.bm;
      end
    end else if (b_small) begin
      if (c_small) begin
        st_d[S_PROD].mode = MODE_ZERO_ROOT;
      end else if (x.cn != x.an) begin
        st_d[S_PROD].mode = MODE_SQRT;
        st_d[S_PROD].n1   = N1_BITS'(x.cm) << (2 * FRAC_BITS);
      end else begin
        st_d[S_PROD].mode = MODE_NONE;
      end
    end else begin
      st_d[S_PROD].mode = MODE_GENERAL;
    end
  end

  // Stage 2: discriminant. A negative value means no roots even when it is tiny.
  always_comb begin
    logic [DISC_BITS-1:0] b2w, p, disc, tol_d;
    pl_t x;
    x     = st_q[S_PROD];
    b2w   = DISC_BITS'(x.b2);
    p     = DISC_BITS'(x.ac) << 2;
    disc  = (x.an ^ x.cn) ? (b2w + p) : (b2w - p);
    tol_d = DISC_BITS'(tol_eff) << FRAC_BITS;
    st_d[S_DISC]     = x;
    st_d[S_DISC].rad = RAD_BITS'(disc);
    if (x.mode == MODE_GENERAL) begin
      if (disc[DISC_BITS-1]) begin
        st_d[S_DISC].mode = MODE_NONE;
      end else if (disc < tol_d) begin
        st_d[S_DISC].mode = MODE_GEN_ONE;
      end else begin
        st_d[S_DISC].mode = MODE_GEN_TWO;
      end
    end
  end

  // First divider: restoring division, one quotient bit per stage.
  for (genvar i = S_DIV1; i < S_SQRT; i++) begin : g_div1
    always_comb begin
      logic [R1_BITS-1:0] r;
      pl_t x;
      x = st_q[i-1];
      r = {x.r1[R1_BITS-2:0], x.n1[N1_BITS-1]};
      st_d[i]    = x;
      st_d[i].n1 = x.n1 << 1;
      if (r >= R1_BITS'(x.d1)) begin
        st_d[i].r1 = r - R1_BITS'(x.d1);
        st_d[i].q1 = {x.q1[N1_BITS-2:0], 1'b1};
      end else begin
        st_d[i].r1 = r;
        st_d[i].q1 = {x.q1[N1_BITS-2:0], 1'b0};
      end
    end
  end

  // Integer square root, two radicand bits and one root bit per stage. The first
  // stage picks the ratio c/a or the discriminant as radicand.
  for (genvar i = S_SQRT; i < S_PREP; i++) begin : g_sqrt
    always_comb begin
      logic [RAD_BITS-1:0]  rad;
      logic [SREM_BITS-1:0] rem, rem_in, trial;
      logic [ROOT_BITS-1:0] root;
      pl_t x;
      x = st_q[i-1];
      if (i == S_SQRT) begin
        rad    = (x.mode == MODE_SQRT) ? RAD_BITS'(x.q1) : x.rad;
        rem_in = '0;
        root   = '0;
      end else begin
        rad    = x.rad;
        rem_in = x.srem;
        root   = x.sroot;
      end
      rem   = {rem_in[SREM_BITS-3:0], rad[RAD_BITS-1:RAD_BITS-2]};
      trial = SREM_BITS'({root, 2'b01});
      st_d[i]     = x;
      st_d[i].rad = rad << 2;
      if (rem >= trial) begin
        st_d[i].srem  = rem - trial;
        st_d[i].sroot = {root[ROOT_BITS-2:0], 1'b1};
      end else begin
        st_d[i].srem  = rem;
        st_d[i].sroot = {root[ROOT_BITS-2:0], 1'b0};
      end
    end
  end

  // Numerators -b - sqrt(D) and -b + sqrt(D) in sign and magnitude; the divisor is 2|a|.
  // With a single root the first numerator is -b alone.
  always_comb begin
    logic [M_BITS:0] negb, s, v1, v2;
    logic [M_BITS:0] m1, m2;
    pl_t x;
    x    = st_q[S_PREP-1];
    negb = x.bn ? (M_BITS + 1)'(x.bm) : -((M_BITS + 1)'(x.bm));
    s    = (M_BITS + 1)'(x.sroot);
    v1   = (x.mode == MODE_GEN_ONE) ? negb : (negb - s);
    v2   = negb + s;
    m1   = v1[M_BITS] ? -v1 : v1;
    m2   = v2[M_BITS] ? -v2 : v2;
    st_d[S_PREP]      = x;
    st_d[S_PREP].neg1 = v1[M_BITS];
    st_d[S_PREP].neg2 = v2[M_BITS];
    st_d[S_PREP].n2a  = N2_BITS'(m1[M_BITS-1:0]) << FRAC_BITS;
    st_d[S_PREP].n2b  = N2_BITS'(m2[M_BITS-1:0]) << FRAC_BITS;
    st_d[S_PREP].d2   = {x.am, 1'b0};
    st_d[S_PREP].r2a  = '0;
    st_d[S_PREP].r2b  = '0;
    st_d[S_PREP].q2a  = '0;
    st_d[S_PREP].q2b  = '0;
  end

  // Second divider pair, both roots side by side, one quotient bit per stage.
  for (genvar i = S_DIV2; i < S_OUT; i++) begin : g_div2
    always_comb begin
      logic [R2_BITS-1:0] ra, rb, dd;
      pl_t x;
      x  = st_q[i-1];
      dd = R2_BITS'(x.d2);
      ra = {x.r2a[R2_BITS-2:0], x.n2a[N2_BITS-1]};
      rb = {x.r2b[R2_BITS-2:0], x.n2b[N2_BITS-1]};
      st_d[i]     = x;
      st_d[i].n2a = x.n2a << 1;
      st_d[i].n2b = x.n2b << 1;
      if (ra >= dd) begin
        st_d[i].r2a = ra - dd;
        st_d[i].q2a = {x.q2a[N2_BITS-2:0], 1'b1};
      end else begin
        st_d[i].r2a = ra;
        st_d[i].q2a = {x.q2a[N2_BITS-2:0], 1'b0};
      end
      if (rb >= dd) begin
        st_d[i].r2b = rb - dd;
        st_d[i].q2b = {x.q2b[N2_BITS-2:0], 1'b1};
      end else begin
        st_d[i].r2b = rb;
        st_d[i].q2b = {x.q2b[N2_BITS-2:0], 1'b0};
      end
    end
  end

  // Apply the sign and clamp to the word range, flagging any clamp.
  function automatic emit_t emit(input logic neg, input logic [EMIT_BITS-1:0] mag);
    logic [EMIT_BITS-1:0] lim;
    emit_t r;
    lim = EMIT_BITS'(1) << (WORD_BITS - 1);
    r.ov = 1'b0;
    if (neg) begin
      if (mag > lim) begin
        r.ov  = 1'b1;
        r.val = lim[WORD_BITS-1:0];
      end else begin
        r.val = -mag[WORD_BITS-1:0];
      end
    end else begin
      if (mag > lim - EMIT_BITS'(1)) begin
        r.ov  = 1'b1;
        r.val = lim[WORD_BITS-1:0] - WORD_BITS'(1);
      end else begin
        r.val = mag[WORD_BITS-1:0];
      end
    end
    return r;
  endfunction

  always_comb begin
    emit_t e1, e2;
    pl_t x;
    x        = st_q[S_OUT-1];
    kind_d   = KIND_NONE;
    first_d  = '0;
    second_d = '0;
    ov_d     = 1'b0;
    e1       = '0;
    e2       = '0;
    unique case (x.mode)
      MODE_ANY: begin
        kind_d = KIND_ANY;
      end
      MODE_LINEAR: begin
        e1      = emit(~x.cn ^ x.bn, EMIT_BITS'(x.q1));
        kind_d  = KIND_ONE;
        first_d = e1.val;
        ov_d    = e1.ov;
      end
      MODE_ZERO_ROOT: begin
        kind_d = KIND_ONE;
      end
      MODE_SQRT: begin
        e1       = emit(1'b1, EMIT_BITS'(x.sroot));
        e2       = emit(1'b0, EMIT_BITS'(x.sroot));
        kind_d   = KIND_TWO;
        first_d  = e1.val;
        second_d = e2.val;
        ov_d     = e1.ov | e2.ov;
      end
      MODE_NONE, MODE_GENERAL: begin
        kind_d = KIND_NONE;
      end
      MODE_GEN_ONE: begin
        e1      = emit(x.neg1 ^ x.an, EMIT_BITS'(x.q2a));
        kind_d  = KIND_ONE;
        first_d = e1.val;
        ov_d    = e1.ov;
      end
      MODE_GEN_TWO: begin
        e1       = emit(x.neg1 ^ x.an, EMIT_BITS'(x.q2a));
        e2       = emit(x.neg2 ^ x.an, EMIT_BITS'(x.q2b));
        kind_d   = KIND_TWO;
        first_d  = e1.val;
        second_d = e2.val;
        ov_d     = e1.ov | e2.ov;
      end
    endcase
  end

  assign out_valid_o   = out_vld_q;
  assign root_kind_o   = kind_q;
  assign root_first_o  = first_q;
  assign root_second_o = second_q;
  assign overflow_o    = ov_q;

endmodule
